// ===== hw/rtl/asf_pkg.sv =====
// shared constants, types and decimal conversion helpers for the sample framer
package asf_pkg;

    localparam int CHANNELS  = 8;
    localparam int DIGITS    = 4;
    localparam int SAMPLE_W  = 12;
    localparam int HALF_W    = SAMPLE_W / 2;
    localparam int BCD_W     = DIGITS * 4;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W     = $clog2(DIGITS + 2);
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] MARK_BYTE    = 8'h41;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] ZERO_CHAR    = 8'h30;

    typedef logic [BCD_W-1:0] t_bcd;

    typedef struct packed {
        t_bcd bcd;
        logic last;
    } t_entry;

    // one shift-add-3 step of binary to bcd conversion
    function automatic t_bcd dabble_step(input t_bcd b, input logic bin);
        t_bcd a;
        a = b;
        for (int d = 0; d < DIGITS; d++) begin
            if (a[d*4 +: 4] >= 4'd5) begin
                a[d*4 +: 4] = a[d*4 +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], bin};
    endfunction

    // half of the conversion: fold in HALF_W bits, msb first
    function automatic t_bcd dabble_half(input t_bcd b, input logic [HALF_W-1:0] bits);
        t_bcd a;
        a = b;
        for (int k = HALF_W - 1; k >= 0; k--) begin
            a = dabble_step(a, bits[k]);
        end
        return a;
    endfunction

endpackage

// ===== hw/rtl/adc_sample_ascii_framer.sv =====
// adc sample framer top level: 12-bit samples in, ascii packet bytes out
//
// input channel: i_valid / i_sample, o_stall. one sample per transaction, channels
// arrive in order 0..CHANNELS-1 and the channel counter wraps after the last one.
// output channel: o_valid / o_out_byte / o_run_last / o_packet_end, i_stall.
// each sample gives 'A' and DIGITS decimal digits with leading zeros, msb first;
// the last channel's sample adds a newline flagged with o_packet_end.
// o_run_last marks the final byte belonging to one sample.
// when the block is idle, the first byte of an accepted sample passes the front
// register, queue write, serializer load and output register before it is valid.
// throughput: the serializer puts out one byte per cycle unless stalled; a sample
// gives five bytes, six for the last channel; samples flow back to back through a
// four-entry queue; the front accepts up to five samples ahead of the serializer.
// when the receiver stalls, the output transaction holds and the queue fills; once
// it is full o_stall rises. reset clears the channel counter, queue and valids.
module adc_sample_ascii_framer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [asf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_stall,
    output logic                         o_valid,
    output logic [7:0]                   o_out_byte,
    output logic                         o_run_last,
    output logic                         o_packet_end,
    input  logic                         i_stall
);
    import asf_pkg::*;

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    t_entry q_wdata;
    t_entry q_rdata;

    asf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    asf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    asf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_packet_end (o_packet_end),
        .i_stall      (i_stall)
    );

endmodule

// ===== hw/rtl/asf_front.sv =====
// front end: takes samples, tracks the channel, converts to bcd, feeds the queue
module asf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [asf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_stall,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output asf_pkg::t_entry              o_q_data
);
    import asf_pkg::*;

    logic              r_s_valid;
    t_bcd              r_s_bcd;
    logic [HALF_W-1:0] r_s_rem;
    logic              r_s_last;
    logic [CH_W-1:0]   r_chan;

    logic s_move;
    logic accept;
    logic last_chan;

    assign last_chan = (r_chan >= CH_W'(CHANNELS - 1));
    assign s_move    = !r_s_valid || !i_q_full;
    assign o_stall   = !s_move;
    assign accept    = i_valid && s_move;
    assign o_q_push  = r_s_valid && !i_q_full;

    always_comb begin
        o_q_data.bcd  = dabble_half(r_s_bcd, r_s_rem);
        o_q_data.last = r_s_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_chan    <= '0;
        end else begin
            if (accept) begin
                r_s_valid <= 1'b1;
                r_chan    <= last_chan ? '0 : r_chan + 1'b1;
            end else if (o_q_push) begin
                r_s_valid <= 1'b0;
            end
        end
    end

    // upper half of the sample is converted on the way in
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_bcd  <= dabble_half('0, i_sample[SAMPLE_W-1:HALF_W]);
            r_s_rem  <= i_sample[HALF_W-1:0];
            r_s_last <= last_chan;
        end
    end

endmodule

// ===== hw/rtl/asf_queue.sv =====
// short fifo between the converting front end and the byte serializer
module asf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  asf_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output asf_pkg::t_entry o_data
);
    import asf_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/asf_back.sv =====
// back end: turns one queued entry into marker, digits and optional newline
module asf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  asf_pkg::t_entry i_q_data,
    output logic            o_q_pop,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_packet_end,
    input  logic            i_stall
);
    import asf_pkg::*;

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_bcd             r_bcd;
    logic             r_last;

    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_run_last;
    logic       r_o_end;

    logic       adv;
    logic       emit;
    logic       is_final;
    logic       is_nl;
    logic [7:0] n_byte;

    assign adv      = !r_o_valid || !i_stall;
    assign emit     = adv && r_busy;
    assign is_nl    = (r_idx == IDX_W'(DIGITS + 1));
    assign is_final = is_nl || ((r_idx == IDX_W'(DIGITS)) && !r_last);
    assign o_q_pop  = !i_q_empty && (!r_busy || (emit && is_final));

    always_comb begin
        if (r_idx == '0) begin
            n_byte = MARK_BYTE;
        end else if (is_nl) begin
            n_byte = NEWLINE_BYTE;
        end else begin
            n_byte = ZERO_CHAR + {4'd0, r_bcd[BCD_W-1 -: 4]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (emit && is_final) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_o_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_idx  <= '0;
            r_bcd  <= i_q_data.bcd;
            r_last <= i_q_data.last;
        end else if (emit) begin
            r_idx <= r_idx + 1'b1;
            // digits leave msb first, so shift the next one to the top
            if (r_idx != '0) begin
                r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
            end
        end
        if (emit) begin
            r_o_byte     <= n_byte;
            r_o_run_last <= is_final;
            r_o_end      <= is_nl;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_byte   = r_o_byte;
    assign o_run_last   = r_o_run_last;
    assign o_packet_end = r_o_end;

endmodule

// ===== bench/adc_sample_ascii_framer_test.sv =====
// self-checking testbench for the adc sample ascii framer: random samples, random stalls
module adc_sample_ascii_framer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import asf_pkg::*;

    localparam int STUCK_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT      = 120;
    localparam int QUIET_FROM   = 60;
    localparam int QUIET_TO     = 110;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] code;
        logic       run_last;
        logic       packet_end;
    } t_ascii_out;

    class framer_scoreboard;
        t_ascii_out       expected_bytes[$];
        logic [CH_W-1:0]  channel = '0;
        int               errors  = 0;

        // expand one accepted sample into its marker, digits and optional newline
        function void note_sample(logic [SAMPLE_W-1:0] s);
            int         value;
            logic       last_ch;
            t_ascii_out e;
            logic [7:0] digit_chars[DIGITS];
            value   = s;
            last_ch = (int'(channel) + 1 >= CHANNELS);
            for (int i = DIGITS - 1; i >= 0; i--) begin
                digit_chars[i] = ZERO_CHAR + 8'(value % 10);
                value = value / 10;
            end
            e = '{MARK_BYTE, 1'b0, 1'b0};
            expected_bytes.push_back(e);
            for (int i = 0; i < DIGITS; i++) begin
                e = '{digit_chars[i], (i == DIGITS - 1) && !last_ch, 1'b0};
                expected_bytes.push_back(e);
            end
            if (last_ch) begin
                e = '{NEWLINE_BYTE, 1'b1, 1'b1};
                expected_bytes.push_back(e);
                channel = '0;
            end else begin
                channel = channel + 1'b1;
            end
        endfunction

        function void check_byte(logic [7:0] code, logic run_last, logic packet_end);
            t_ascii_out e;
            if (expected_bytes.size() == 0) begin
                $error("unexpected output byte %h", code);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (code !== e.code) begin
                $error("out_byte expected %h actual %h", e.code, code);
                errors++;
            end
            if (run_last !== e.run_last) begin
                $error("run_last expected %b actual %b", e.run_last, run_last);
                errors++;
            end
            if (packet_end !== e.packet_end) begin
                $error("packet_end expected %b actual %b", e.packet_end, packet_end);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [SAMPLE_W-1:0] i_sample = '0;
    logic                o_stall;
    logic                o_valid;
    logic [7:0]          o_out_byte;
    logic                o_run_last;
    logic                o_packet_end;
    logic                i_stall = 1'b0;

    framer_scoreboard sb = new;
    int               n_accepted = 0;
    int               stuck_cycles = 0;

    adc_sample_ascii_framer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_sample     (i_sample),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_packet_end (o_packet_end),
        .i_stall      (i_stall)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic quiet_stretch();
        return n_accepted >= QUIET_FROM && n_accepted < QUIET_TO;
    endfunction

    // monitor: both channels and the watchdog at the rising edge
    always @(posedge i_clk) begin
        logic moved;
        moved = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_sample(i_sample);
            n_accepted <= n_accepted + 1;
            moved = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_byte(o_out_byte, o_run_last, o_packet_end);
            moved = 1'b1;
        end
        if (moved) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // receiver: random stall, plus one long hold while the sender keeps offering
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (quiet_stretch()) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 36);
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        @(negedge i_clk);
        while (!quiet_stretch() && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_for_empty();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            6: return SAMPLE_W'($urandom_range(99));
            7: begin
                case ($urandom_range(2))
                    0: return SAMPLE_W'(9 + $urandom_range(2));
                    1: return SAMPLE_W'(99 + $urandom_range(2));
                    default: return SAMPLE_W'(999 + $urandom_range(2));
                endcase
            end
            8: return SAMPLE_W'(4000 + $urandom_range(95));
            9: return $urandom_range(1) ? '1 : '0;
            default: return SAMPLE_W'($urandom_range(4095));
        endcase
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] directed[$];
        directed = '{12'd0, 12'd4095, 12'd1, 12'd9, 12'd10, 12'd99, 12'd100, 12'd999,
                     12'd1000, 12'd4094, 12'd2048, 12'h555, 12'hAAA, 12'd1234,
                     12'd3000, 12'd7};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) send_sample(directed[k]);
        // sender pause until the block has drained
        wait_for_empty();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            send_sample(random_sample());
            if (k == 200) wait_for_empty();
        end

        wait_for_empty();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected bytes never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/asf_pkg.sv
hw/rtl/asf_front.sv
hw/rtl/asf_queue.sv
hw/rtl/asf_back.sv
hw/rtl/adc_sample_ascii_framer.sv
bench/adc_sample_ascii_framer_test.sv
